/* design/dq_pkg.sv */
// Shared definitions for the double-ended queue: command and status codes,
// the memory request struct and default sizes. No dependencies.
package dq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_READ_INDEX = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

endpackage

/* design/double_ended_queue.sv */
// Top level of the bounded double-ended queue.
// Instantiates dq_ctrl and dq_ram; depends on dq_pkg.
//
// Usage:
//   Command channel: drive cmd, push_value and position with start high; the
//   word is taken at the rising edge where start is high and busy is low.
//   busy stays low, so a new command may be issued in every cycle.
//   Result channel: exactly one result word per command. done is high for
//   one cycle, the cycle right after the command was taken, with read_value,
//   status, occupancy and is_void valid in that cycle only.
//   Throughput is one command per cycle: the ring memory is single ported
//   with a registered read, and each command makes at most one access to
//   it, addressed at the accept edge.
//   The receiver cannot hold results off; it must take each result in its
//   done cycle.
//   Reset (rst, synchronous) empties the queue and sets the front position
//   to zero. Ring contents are not cleared; only entries that hold data are
//   ever read.
module double_ended_queue #(
  parameter int DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd,
  input  logic [WORD_BITS-1:0]         push_value,
  input  logic [$clog2(DEPTH)-1:0]     position,
  output logic                         done,
  output logic [WORD_BITS-1:0]         read_value,
  output logic [1:0]                   status,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy,
  output logic                         is_void
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_req_t             mem_req;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rd_data;

  // Commands never stall; busy is tied low.
  assign busy = 1'b0;

  dq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .push_value (push_value),
    .position   (position),
    .mem_req    (mem_req),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .rd_data    (rd_data),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .occupancy  (occupancy),
    .is_void    (is_void)
  );

  dq_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .req     (mem_req),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (rd_data)
  );

endmodule

/* design/dq_ram.sv */
// Ring storage for the double-ended queue: single-port synchronous memory
// with registered read data. Depends on dq_pkg for the request struct.
module dq_ram #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  dq_pkg::mem_req_t     req,
  input  logic [AW-1:0]        addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rd_data
);
  import dq_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  // A command either writes or reads, never both.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= wdata;
    end
    if (req.re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* design/dq_ctrl.sv */
// Front position and count tracking, ring address generation and result
// registers for the double-ended queue. Depends on dq_pkg.
module dq_ctrl #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           cmd,
  input  logic [WORD_BITS-1:0] push_value,
  input  logic [AW-1:0]        position,
  output dq_pkg::mem_req_t     mem_req,
  output logic [AW-1:0]        mem_addr,
  output logic [WORD_BITS-1:0] mem_wdata,
  input  logic [WORD_BITS-1:0] rd_data,
  output logic                 done,
  output logic [WORD_BITS-1:0] read_value,
  output logic [1:0]           status,
  output logic [CW-1:0]        occupancy,
  output logic                 is_void
);
  import dq_pkg::*;

  localparam int SW = AW + 1;

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          rd_ok;
  logic          rd_ok_next;
  status_t       st_next;
  logic          wr;
  logic          rd;
  logic          is_full;
  logic          no_entries;
  logic [SW-1:0] off;
  logic [SW-1:0] sum;
  logic [AW-1:0] slot;
  cmd_t          cmd_c;

  assign cmd_c      = cmd_t'(cmd);
  assign is_full    = (SW'(count) == SW'(DEPTH));
  assign no_entries = (count == '0);

  // Offset from the front that this command needs.
  always_comb begin
    case (cmd_c)
      CMD_PUSH_FRONT: off = SW'(DEPTH - 1);
      CMD_PUSH_BACK:  off = SW'(count);
      CMD_POP_FRONT,
      CMD_PEEK_FRONT: off = SW'(1);
      CMD_POP_BACK,
      CMD_PEEK_BACK:  off = SW'(count) - SW'(1);
      CMD_READ_INDEX: off = SW'(position);
      default:        off = '0;
    endcase
  end

  // Wrap front + offset into the ring; a used sum is below twice the depth.
  assign sum  = SW'(front) + off;
  assign slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);

  always_comb begin
    front_next = front;
    count_next = count;
    st_next    = ST_OK;
    rd_ok_next = 1'b0;
    wr         = 1'b0;
    rd         = 1'b0;
    mem_addr   = slot;
    case (cmd_c)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          st_next = ST_FULL;
        end else begin
          wr         = 1'b1;
          front_next = slot;
          count_next = count + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          st_next = ST_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        mem_addr = front;
        if (no_entries) begin
          st_next = ST_EMPTY;
        end else begin
          rd         = 1'b1;
          rd_ok_next = 1'b1;
          if (cmd_c == CMD_POP_FRONT) begin
            front_next = slot;
            count_next = count - CW'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (no_entries) begin
          st_next = ST_EMPTY;
        end else begin
          rd         = 1'b1;
          rd_ok_next = 1'b1;
          if (cmd_c == CMD_POP_BACK) begin
            count_next = count - CW'(1);
          end
        end
      end
      CMD_READ_INDEX: begin
        if (SW'(position) >= SW'(count)) begin
          st_next = ST_EMPTY;
        end else begin
          rd         = 1'b1;
          rd_ok_next = 1'b1;
        end
      end
      CMD_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
        front_next = front;
      end
    endcase
  end

  assign mem_req.we = start & wr;
  assign mem_req.re = start & rd;
  assign mem_wdata  = push_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  // Result word fields; qualified by done.
  always_ff @(posedge clk) begin
    if (start) begin
      status    <= st_next;
      rd_ok     <= rd_ok_next;
      occupancy <= count_next;
      is_void   <= (count_next == '0);
    end
  end

  // Zero the data unless this command read a live entry.
  assign read_value = rd_ok ? rd_data : '0;

endmodule

/* design/dq_checker.sv */
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg for command and status codes.
module dq_checker #(
  parameter int DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [2:0]                 cmd,
  input logic                       done,
  input logic [WORD_BITS-1:0]       read_value,
  input logic [1:0]                 status,
  input logic [$clog2(DEPTH+1)-1:0] occupancy,
  input logic                       is_void
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // One result word in the cycle after each accepted command, none otherwise.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy && !rst))
    else $error("result strobe does not match accepted command");

  a_void_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_void == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == CW'(DEPTH)))
    else $error("push dropped while queue not full");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (read_value == '0))
    else $error("data not zero on failed command");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd) == CMD_CLEAR) |-> (occupancy == '0 && status == ST_OK))
    else $error("clear left entries behind");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH     (DEPTH),
  .WORD_BITS (WORD_BITS)
) u_dq_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .done       (done),
  .read_value (read_value),
  .status     (status),
  .occupancy  (occupancy),
  .is_void    (is_void)
);
